### rtl/hour_strike_chime_sequencer_top_assert.svh
// Assertion macros for the hour strike chime sequencer.
`ifndef HOUR_STRIKE_CHIME_SEQUENCER_TOP_ASSERT_SVH
`define HOUR_STRIKE_CHIME_SEQUENCER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define HSCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hscs assertion failed");

// Check cons in the cycle after ante.
`define HSCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hscs assertion failed");

`endif

### rtl/hscs_pkg.sv
// Shared types and constants of the hour strike chime sequencer.
package hscs_pkg;

  localparam int unsigned HourW     = 5;
  localparam int unsigned MinW      = 6;
  localparam int unsigned SecW      = 6;
  localparam int unsigned CountW    = 4;
  localparam int unsigned TickW     = 7;
  localparam int unsigned IntvW     = 6;
  localparam int unsigned GrpW      = 4;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned DivSteps  = MinW;
  localparam int unsigned DivCntW   = 3;

  localparam logic [IntvW-1:0] IntervalRst = 6'd15;
  localparam logic [TickW-1:0] LengthRst   = 7'd10;
  localparam logic [TickW-1:0] GapRst      = 7'd10;
  localparam logic [TickW-1:0] PauseRst    = 7'd30;
  localparam logic [GrpW-1:0]  GroupRst    = 4'd3;

  localparam logic [HourW-1:0]  HalfDay    = 5'd12;
  localparam logic [CountW-1:0] MidnightCt = 4'd12;
  localparam logic [CountW-1:0] MaxCount   = 4'd15;

  typedef enum logic [CfgAddrW-1:0] {
    CfgChimeInterval = 3'd0,
    CfgBeepLength    = 3'd1,
    CfgBeepGap       = 3'd2,
    CfgPauseGap      = 3'd3,
    CfgGroupSize     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OpTimeCheck = 1'b0,
    OpTick      = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StUpd  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic update;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/hscs_ctrl.sv
// Controller state machine of the hour strike chime sequencer.
module hscs_ctrl import hscs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_tvalid_i,
  output logic       in_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_tready_o = (state_q == StIdle);

endmodule

### rtl/hscs_dp.sv
// Datapath of the hour strike chime sequencer: registers, remainder unit, pattern state.
module hscs_dp import hscs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_tuser_i,
  input  logic [InTdataW-1:0]  in_tdata_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic                 out_tready_i,
  output logic                 out_tvalid_o,
  output logic [OutTdataW-1:0] out_tdata_o
);

  logic [IntvW-1:0] chime_interval_q;
  logic [TickW-1:0] beep_length_q, beep_gap_q, pause_gap_q;
  logic [GrpW-1:0]  group_size_q;

  op_e              op_q;
  logic [HourW-1:0] hour_q;
  logic [MinW-1:0]  minute_q;
  logic [SecW-1:0]  second_q;
  logic             enable_q;

  logic [MinW-1:0]    num_q, num_d;
  logic [MinW-1:0]    rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [MinW-1:0]    den;
  logic [MinW:0]      shifted;

  logic              active_q, active_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] index_q, index_d;
  logic              in_gap_q, in_gap_d;
  logic [TickW-1:0]  ticks_q, ticks_d;
  logic              buzzer_q, buzzer_d;

  logic              out_valid_q;
  logic [1:0]        out_data_q;

  logic [TickW-1:0]  length_eff, gap_eff, pause_eff, gap_sel, ticks_dec;
  logic [HourW-1:0]  hour_over;
  logic [CountW-1:0] count;
  logic              match;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chime_interval_q <= IntervalRst;
      beep_length_q    <= LengthRst;
      beep_gap_q       <= GapRst;
      pause_gap_q      <= PauseRst;
      group_size_q     <= GroupRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgChimeInterval: chime_interval_q <= cfg_wdata_i[IntvW-1:0];
        CfgBeepLength:    beep_length_q    <= cfg_wdata_i[TickW-1:0];
        CfgBeepGap:       beep_gap_q       <= cfg_wdata_i[TickW-1:0];
        CfgPauseGap:      pause_gap_q      <= cfg_wdata_i[TickW-1:0];
        CfgGroupSize:     group_size_q     <= cfg_wdata_i[GrpW-1:0];
        default: ;
      endcase
    end
  end

  // Input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(in_tuser_i);
      hour_q   <= in_tdata_i[HourW-1:0];
      minute_q <= in_tdata_i[HourW +: MinW];
      second_q <= in_tdata_i[HourW+MinW +: SecW];
      enable_q <= in_tdata_i[HourW+MinW+SecW];
    end
  end

  // Restoring remainder, one dividend bit per step
  assign den     = (op_q == OpTick) ? MinW'(group_size_q) : chime_interval_q;
  assign shifted = {rem_q, num_q[MinW-1]};

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      num_d = (op_e'(in_tuser_i) == OpTick) ? MinW'(index_q) + MinW'(1)
                                            : in_tdata_i[HourW +: MinW];
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      num_d = {num_q[MinW-2:0], 1'b0};
      rem_d = (shifted >= {1'b0, den}) ? MinW'(shifted - {1'b0, den}) : MinW'(shifted);
      cnt_d = cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign status_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));
  assign status_o.out_free = !out_valid_q || out_tready_i;

  // Pattern update
  assign length_eff = (beep_length_q == '0) ? TickW'(1) : beep_length_q;
  assign gap_eff    = (beep_gap_q == '0)    ? TickW'(1) : beep_gap_q;
  assign pause_eff  = (pause_gap_q == '0)   ? TickW'(1) : pause_gap_q;
  assign gap_sel    = (group_size_q != '0 && index_q != '0 && rem_q == '0) ? pause_eff
                                                                           : gap_eff;
  assign ticks_dec  = ticks_q - TickW'(1);
  assign hour_over  = hour_q - HalfDay;
  assign match      = enable_q && (second_q == '0) && (rem_q == '0);

  always_comb begin
    if (minute_q != '0) begin
      count = CountW'(1);
    end else if (hour_q == '0) begin
      count = MidnightCt;
    end else if (hour_q > HalfDay) begin
      count = (hour_over > HourW'(MaxCount)) ? MaxCount : hour_over[CountW-1:0];
    end else begin
      count = hour_q[CountW-1:0];
    end
  end

  always_comb begin
    active_d = active_q;
    total_d  = total_q;
    index_d  = index_q;
    in_gap_d = in_gap_q;
    ticks_d  = ticks_q;
    buzzer_d = buzzer_q;
    if (cmd_i.update) begin
      if (op_q == OpTimeCheck) begin
        if (match) begin
          active_d = 1'b1;
          total_d  = count;
          index_d  = '0;
          in_gap_d = 1'b0;
          ticks_d  = length_eff;
        end
      end else if (active_q) begin
        if (index_q >= total_q) begin
          buzzer_d = 1'b0;
          active_d = 1'b0;
        end else if (!in_gap_q) begin
          buzzer_d = 1'b1;
          ticks_d  = ticks_dec;
          if (ticks_dec == '0) begin
            in_gap_d = 1'b1;
            ticks_d  = gap_sel;
          end
        end else begin
          buzzer_d = 1'b0;
          ticks_d  = ticks_dec;
          if (ticks_dec == '0) begin
            in_gap_d = 1'b0;
            index_d  = index_q + CountW'(1);
            ticks_d  = length_eff;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      total_q  <= '0;
      index_q  <= '0;
      in_gap_q <= 1'b0;
      ticks_q  <= '0;
      buzzer_q <= 1'b0;
    end else begin
      active_q <= active_d;
      total_q  <= total_d;
      index_q  <= index_d;
      in_gap_q <= in_gap_d;
      ticks_q  <= ticks_d;
      buzzer_q <= buzzer_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {active_q, buzzer_q};
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {(OutTdataW-2)'(0), out_data_q};

endmodule

### rtl/hour_strike_chime_sequencer_top.sv
// Top level of the hour strike chime sequencer.
// Each input word yields one output word. A word passes a capture step, six
// steps of the bit-serial remainder unit (minute modulo chime_interval for a
// time check, beep number modulo group_size for a tick), an update step and
// an output load, which waits until the output register is free. Words are
// handled one at a time; the result sits in an output register while the
// next word is accepted. Configuration writes take effect at once.
`include "hour_strike_chime_sequencer_top_assert.svh"

module hour_strike_chime_sequencer_top import hscs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [17] chime_enable, rest zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // [0] op
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] buzzer_on, [1] chime_active, rest zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  hscs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hscs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tuser_i   (s_axis_tuser),
    .in_tdata_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

  `HSCS_ASSERT_NEXT(a_one_word_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `HSCS_ASSERT_NOW(a_buzzer_only_when_active, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1])
  `HSCS_ASSERT_NOW(a_load_only_when_ready, clk_i, rst_ni, cmd.load, s_axis_tready && s_axis_tvalid)

endmodule

### tb/hour_strike_chime_sequencer_top_test.sv
// Stream testbench for the hour strike chime sequencer, checked against a cycle-free predictor.
`timescale 1ns / 100ps

module hour_strike_chime_sequencer_top_test import hscs_pkg::*;;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned BusyTarget = 1400;

  typedef struct packed {
    logic act;
    logic buzz;
  } chime_lv_t;

  typedef enum logic {
    RowWord,
    RowRegs
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic [HourW-1:0]   hour;
    logic [MinW-1:0]    minute;
    logic [SecW-1:0]    second;
    logic               en;
    bit                 typed;
    chime_lv_t          want;
    logic [CfgDataW-1:0] iv, bl, bg, pg, gs;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgAddrW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [4:0] hour, [10:5] minute, [16:11] second, [17] chime_enable, rest zero
  logic [InTdataW-1:0]  s_axis_tdata;
  // [0] op
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [0] buzzer_on, [1] chime_active, rest zero
  logic [OutTdataW-1:0] m_axis_tdata;

  // Predictor configuration and chime state.
  logic [IntvW-1:0]  iv_r;
  logic [TickW-1:0]  len_r, gap_r, pause_r;
  logic [GrpW-1:0]   grp_r;
  logic              ch_active, ch_gap, ch_buzz;
  logic [CountW-1:0] ch_total, ch_index;
  logic [TickW-1:0]  ch_left;

  chime_lv_t due_levels[$];
  dir_row_t  dir_tab[$];

  int unsigned errs, cycles, busy_words, words_sent, chimes_started, chimes_done, reg_phases;
  int unsigned snd_idle_pct, rcv_idle_pct;
  bit          hold_req;

  hour_strike_chime_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("hour_strike_chime_sequencer_top_test: done, errors");
    $finish;
  end

  function automatic logic [TickW-1:0] at_least_one(logic [TickW-1:0] v);
    return (v == 0) ? TickW'(1) : v;
  endfunction

  function automatic logic [TickW-1:0] gap_len(logic [CountW-1:0] i);
    if (grp_r != 0 && i != 0 && ((int'(i) + 1) % int'(grp_r)) == 0) return at_least_one(pause_r);
    return at_least_one(gap_r);
  endfunction

  function automatic int strike_count(logic [HourW-1:0] hour, logic [MinW-1:0] minute);
    int cnt;
    if (minute != 0) cnt = 1;
    else if (hour == 0) cnt = 12;
    else if (hour > 12) cnt = int'(hour) - 12;
    else cnt = int'(hour);
    return (cnt > 15) ? 15 : cnt;
  endfunction

  function automatic chime_lv_t next_levels(op_e op, logic [HourW-1:0] hour,
                                            logic [MinW-1:0] minute, logic [SecW-1:0] second,
                                            logic en);
    chime_lv_t lv;
    logic      hit;
    if (op == OpTimeCheck) begin
      if (en && second == 0) begin
        hit = (iv_r == 0) ? (minute == 0) : ((minute % iv_r) == 0);
        if (hit) begin
          ch_active = 1'b1;
          ch_total  = CountW'(strike_count(hour, minute));
          ch_index  = '0;
          ch_gap    = 1'b0;
          ch_left   = at_least_one(len_r);
          busy_words++;
          chimes_started++;
        end
      end
    end else if (ch_active) begin
      busy_words++;
      if (ch_index >= ch_total) begin
        ch_buzz   = 1'b0;
        ch_active = 1'b0;
        chimes_done++;
      end else if (!ch_gap) begin
        ch_buzz = 1'b1;
        ch_left = ch_left - TickW'(1);
        if (ch_left == 0) begin
          ch_gap  = 1'b1;
          ch_left = gap_len(ch_index);
        end
      end else begin
        ch_buzz = 1'b0;
        ch_left = ch_left - TickW'(1);
        if (ch_left == 0) begin
          ch_gap   = 1'b0;
          ch_index = ch_index + CountW'(1);
          ch_left  = at_least_one(len_r);
        end
      end
    end
    lv.buzz = ch_buzz;
    lv.act  = ch_active;
    return lv;
  endfunction

  task automatic check_levels(logic [OutTdataW-1:0] got);
    chime_lv_t want;
    if (due_levels.size() == 0) begin
      $display("%0t: unexpected word, got buzzer_on %0b chime_active %0b",
               $time, got[0], got[1]);
      errs++;
    end else begin
      want = due_levels.pop_front();
      if (got[0] !== want.buzz) begin
        $display("%0t: buzzer_on expected %0b got %0b", $time, want.buzz, got[0]);
        errs++;
      end
      if (got[1] !== want.act) begin
        $display("%0t: chime_active expected %0b got %0b", $time, want.act, got[1]);
        errs++;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_levels(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic offer_word(op_e op, logic [HourW-1:0] hour, logic [MinW-1:0] minute,
                            logic [SecW-1:0] second, logic en, bit typed = 1'b0,
                            chime_lv_t want = '0);
    chime_lv_t lv;
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, en, second, minute, hour};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    lv = next_levels(op, hour, minute, second, en);
    due_levels.push_back(typed ? want : lv);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic poke(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgChimeInterval: iv_r    = val[IntvW-1:0];
      CfgBeepLength:    len_r   = val;
      CfgBeepGap:       gap_r   = val;
      CfgPauseGap:      pause_r = val;
      CfgGroupSize:     grp_r   = val[GrpW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [CfgDataW-1:0] iv, logic [CfgDataW-1:0] bl,
                              logic [CfgDataW-1:0] bg, logic [CfgDataW-1:0] pg,
                              logic [CfgDataW-1:0] gs);
    drain();
    poke(CfgChimeInterval, iv);
    poke(CfgBeepLength, bl);
    poke(CfgBeepGap, bg);
    poke(CfgPauseGap, pg);
    poke(CfgGroupSize, gs);
    cfg_we_i <= 1'b0;
    reg_phases++;
  endtask

  function automatic dir_row_t word_row(op_e op, int hour, int minute, int second, bit en,
                                        bit typed = 1'b0, bit act = 1'b0, bit buzz = 1'b0);
    dir_row_t r;
    r = '{kind: RowWord, op: op, hour: HourW'(hour), minute: MinW'(minute),
          second: SecW'(second), en: en, typed: typed, want: '{act: act, buzz: buzz},
          iv: '0, bl: '0, bg: '0, pg: '0, gs: '0};
    return r;
  endfunction

  function automatic dir_row_t regs_row(int iv, int bl, int bg, int pg, int gs);
    dir_row_t r;
    r = word_row(OpTick, 0, 0, 0, 1'b0);
    r.kind = RowRegs;
    r.iv = CfgDataW'(iv);
    r.bl = CfgDataW'(bl);
    r.bg = CfgDataW'(bg);
    r.pg = CfgDataW'(pg);
    r.gs = CfgDataW'(gs);
    return r;
  endfunction

  initial begin
    dir_row_t         row;
    logic [HourW-1:0] h;
    logic [MinW-1:0]  m;
    logic [SecW-1:0]  s;
    int               sel, cnt, est, seq_ticks, phase_end, gp;
    bit               held, paused;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CfgChimeInterval;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpTimeCheck;
    iv_r = IntervalRst;
    len_r = LengthRst;
    gap_r = GapRst;
    pause_r = PauseRst;
    grp_r = GroupRst;
    ch_active = 1'b0;
    ch_gap = 1'b0;
    ch_buzz = 1'b0;
    ch_total = '0;
    ch_index = '0;
    ch_left = '0;
    errs = 0;
    busy_words = 0;
    words_sent = 0;
    chimes_started = 0;
    chimes_done = 0;
    reg_phases = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b0;
    held = 1'b0;
    paused = 1'b0;

    // Directed rows, starting from the reset register values.
    dir_tab.push_back(word_row(OpTick,      0,  0,  0, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 0,  0,  0, 1'b0, 1'b1, 1'b0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 0,  0, 59, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 5,  7,  0, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 31, 63, 63, 1'b1, 1'b1, 1'b0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 0,  0,  0, 1'b1, 1'b1, 1'b1, 1'b0));
    dir_tab.push_back(word_row(OpTick,      0,  0,  0, 1'b0, 1'b1, 1'b1, 1'b1));
    dir_tab.push_back(word_row(OpTimeCheck, 3, 30,  0, 1'b1));
    dir_tab.push_back(regs_row(0, 0, 0, 0, 0));
    repeat (4) dir_tab.push_back(word_row(OpTick, 0, 0, 0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 23, 0, 0, 1'b1));
    dir_tab.push_back(word_row(OpTimeCheck, 12, 30, 0, 1'b1));
    repeat (2) dir_tab.push_back(word_row(OpTick, 0, 0, 0, 1'b1));
    dir_tab.push_back(regs_row(127, 127, 127, 127, 15));
    dir_tab.push_back(word_row(OpTimeCheck, 31, 0, 0, 1'b1));
    dir_tab.push_back(word_row(OpTimeCheck, 20, 63, 0, 1'b1));
    repeat (2) dir_tab.push_back(word_row(OpTick, 0, 0, 0, 1'b0));
    dir_tab.push_back(regs_row(1, 1, 1, 1, 1));
    dir_tab.push_back(word_row(OpTimeCheck, 12, 59, 0, 1'b1));
    repeat (4) dir_tab.push_back(word_row(OpTick, 0, 0, 0, 1'b0));
    dir_tab.push_back(word_row(OpTimeCheck, 13, 0, 0, 1'b1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == RowRegs) program_regs(row.iv, row.bl, row.bg, row.pg, row.gs);
      else offer_word(row.op, row.hour, row.minute, row.second, row.en, row.typed, row.want);
    end

    while (words_sent < BusyTarget) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) program_regs(CfgDataW'(60), CfgDataW'(127), CfgDataW'(127),
                                 CfgDataW'(127), CfgDataW'(12));
      else if (sel == 1) program_regs(CfgDataW'(1), CfgDataW'(1), CfgDataW'(1),
                                      CfgDataW'(1), CfgDataW'(1));
      else program_regs(CfgDataW'(($urandom_range(99) < 10) ? $urandom_range(0, 127)
                                                            : $urandom_range(1, 60)),
                        CfgDataW'($urandom_range(0, 6)), CfgDataW'($urandom_range(0, 6)),
                        CfgDataW'($urandom_range(0, 10)), CfgDataW'($urandom_range(0, 15)));
      if (words_sent < BusyTarget / 3) begin
        snd_idle_pct = 13;
        rcv_idle_pct = 52;
      end else if (words_sent < 2 * BusyTarget / 3) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 13;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      phase_end = words_sent + 150;
      while (words_sent < phase_end) begin
        if (!held && words_sent >= 700) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (!paused && words_sent >= 1000) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          h = HourW'(($urandom_range(99) < 85) ? $urandom_range(0, 23)
                                               : $urandom_range(24, 31));
          if (iv_r == 0 || $urandom_range(99) < 40) m = '0;
          else m = MinW'($urandom_range(0, 63 / iv_r) * iv_r);
          offer_word(OpTimeCheck, h, m, '0, 1'b1);
          cnt = strike_count(h, m);
          gp = (at_least_one(gap_r) > at_least_one(pause_r)) ? int'(at_least_one(gap_r))
                                                                : int'(at_least_one(pause_r));
          est = cnt * (int'(at_least_one(len_r)) + gp) + 2;
          if (est > 300) est = 300;
          seq_ticks = ($urandom_range(99) < 60) ? est : int'($urandom_range(1, unsigned'(est)));
          repeat (seq_ticks) begin
            if ($urandom_range(99) < 5)
              offer_word(OpTimeCheck, HourW'($urandom_range(0, 31)), MinW'($urandom_range(0, 63)),
                         SecW'($urandom_range(0, 1) ? 0 : $urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            else
              offer_word(OpTick, HourW'($urandom_range(0, 31)), MinW'($urandom_range(0, 63)),
                         SecW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          end
        end else begin
          s = SecW'($urandom_range(0, 1) ? 0 : $urandom_range(0, 63));
          offer_word(op_e'($urandom_range(0, 1)), HourW'($urandom_range(0, 31)),
                     MinW'($urandom_range(0, 63)), s, 1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d words over %0d register settings, %0d started or stepped a chime",
             words_sent, reg_phases, busy_words);
    $display("%0d chimes started, %0d played out", chimes_started, chimes_done);
    if (errs == 0) $display("hour_strike_chime_sequencer_top_test: done, clean");
    else $display("hour_strike_chime_sequencer_top_test: done, errors");
    $finish;
  end

endmodule
